/* sv/adctm_pkg.sv */
// Shared constants and types for the converter sample store with trimmed-mean read-out.
`default_nettype none
package adctm_pkg;

    localparam int CHANNELS     = 8;
    localparam int HIST_DEPTH   = 3;
    localparam int SAMPLE_BITS  = 12;

    localparam int CH_W         = $clog2(CHANNELS);
    localparam int HIST_ENTRIES = CHANNELS * HIST_DEPTH;
    localparam int HIST_AW      = $clog2(HIST_ENTRIES);
    localparam int CNT_W        = $clog2(HIST_DEPTH);
    localparam int SUM_W        = SAMPLE_BITS + $clog2(HIST_DEPTH);
    localparam int TRIM_COUNT   = HIST_DEPTH - 2;

    localparam int FS_W         = 16;
    localparam int VALUE_W      = 16;
    localparam int SCALE_SHIFT  = 12;
    localparam int PROD_W       = SAMPLE_BITS + FS_W;

    localparam int TDATA_W      = 16;
    localparam int TUSER_W      = 3;
    localparam int USER_CMD     = 0;
    localparam int USER_REC     = 1;
    localparam int USER_DEB     = 2;

    localparam int CFG_IDX_W    = 1;
    localparam logic [FS_W-1:0] FULL_SCALE_RESET = FS_W'(3300);

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

endpackage
`default_nettype wire

/* sv/adc_trimmed_mean_sampler.sv */
// Top level of the converter sample store with history ring and trimmed-mean read-out.
`default_nettype none
// A store request, while the block is enabled, writes the channel's latest sample and,
// when recording, its history ring entry in the cycle it is accepted, so store requests
// flow at one per cycle while no read is in progress. A read request returns one scaled
// value: a latest-sample read goes through the RAM read, select and output registers; a
// trimmed-mean read walks the history memory one entry per cycle through its single read port.
// Requests are taken one at a time; a new request is accepted while a finished result
// still waits in the output register, but a second result holds the block in its last
// step until the output register is free. All stores read as zero after reset.
module adc_trimmed_mean_sampler
    import adctm_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [TDATA_W-1:0]   s_axis_tdata,   // channel, sample, zero pad
    input  wire  [TUSER_W-1:0]   s_axis_tuser,   // command, record_history, use_debounced
    input  wire                  s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // value
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [FS_W-1:0]      i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LATEST,
        S_HIST,
        S_SCALE
    } t_state;

    t_state                r_state;
    logic                  r_enabled;
    logic [FS_W-1:0]       r_full_scale;
    logic [CNT_W-1:0]      r_ring_idx;
    logic [CNT_W-1:0]      r_cnt;
    logic [HIST_AW-1:0]    r_base;
    logic [CHANNELS-1:0]   r_lat_vld;
    logic [HIST_ENTRIES-1:0] r_hist_vld;
    logic                  r_lat_vld_q;
    logic                  r_hist_vld_q;
    t_sample               r_lo;
    t_sample               r_hi;
    logic [SUM_W-1:0]      r_sum;
    t_sample               r_sel;

    logic                  accept;
    logic                  in_cmd;
    logic                  in_rec;
    logic                  in_deb;
    logic [CH_W-1:0]       in_ch;
    t_sample               in_smp;
    logic                  store_we;
    logic                  hist_we;
    logic [HIST_AW-1:0]    in_base;
    logic [HIST_AW-1:0]    hist_waddr;
    logic [HIST_AW-1:0]    hist_raddr;
    t_sample               lat_rdata;
    t_sample               hist_rdata;
    t_sample               hist_v;
    t_sample               n_lo;
    t_sample               n_hi;
    logic [SUM_W-1:0]      n_sum;
    logic [SUM_W-1:0]      trimmed;
    logic [PROD_W-1:0]     product;
    logic                  out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_cmd = s_axis_tuser[USER_CMD];
    assign in_rec = s_axis_tuser[USER_REC];
    assign in_deb = s_axis_tuser[USER_DEB];
    assign in_ch  = s_axis_tdata[CH_W-1:0];
    assign in_smp = s_axis_tdata[CH_W +: SAMPLE_BITS];

    assign store_we   = accept && (in_cmd == CMD_STORE) && r_enabled;
    assign hist_we    = store_we && in_rec;
    assign in_base    = HIST_AW'(in_ch) * HIST_AW'(HIST_DEPTH);
    assign hist_waddr = in_base + HIST_AW'(r_ring_idx);
    assign hist_raddr = (r_state == S_IDLE) ? in_base
                                            : r_base + HIST_AW'(r_cnt) + HIST_AW'(1);

    adctm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (CHANNELS)
    ) u_latest (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (in_ch),
        .i_wdata (in_smp),
        .i_raddr (in_ch),
        .o_rdata (lat_rdata)
    );

    adctm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (HIST_ENTRIES)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (in_smp),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    always_comb begin
        hist_v = r_hist_vld_q ? hist_rdata : '0;
        if (r_cnt == '0) begin
            n_lo  = hist_v;
            n_hi  = hist_v;
            n_sum = SUM_W'(hist_v);
        end else begin
            n_lo  = (hist_v < r_lo) ? hist_v : r_lo;
            n_hi  = (hist_v > r_hi) ? hist_v : r_hi;
            n_sum = r_sum + SUM_W'(hist_v);
        end
        trimmed = SUM_W'((n_sum - SUM_W'(n_lo) - SUM_W'(n_hi)) / TRIM_COUNT);
    end

    assign product  = PROD_W'(r_sel) * PROD_W'(r_full_scale);
    assign out_free = !m_axis_tvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_enabled     <= 1'b0;
            r_full_scale  <= FULL_SCALE_RESET;
            r_ring_idx    <= '0;
            r_cnt         <= '0;
            r_lat_vld     <= '0;
            r_hist_vld    <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ENABLED:    r_enabled    <= i_cfg_data[0];
                    REG_FULL_SCALE: r_full_scale <= i_cfg_data;
                    default: ;
                endcase
            end

            if ((r_state == S_SCALE) && out_free) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end

            r_lat_vld_q  <= r_lat_vld[in_ch];
            r_hist_vld_q <= r_hist_vld[hist_raddr];

            case (r_state)
                S_IDLE: begin
                    r_cnt  <= '0;
                    r_base <= in_base;
                    if (store_we) begin
                        r_lat_vld[in_ch] <= 1'b1;
                        if (in_rec) begin
                            r_hist_vld[hist_waddr] <= 1'b1;
                            if (s_axis_tlast) begin
                                r_ring_idx <= (r_ring_idx == CNT_W'(HIST_DEPTH - 1))
                                              ? '0 : r_ring_idx + CNT_W'(1);
                            end
                        end
                    end
                    if (accept && (in_cmd == CMD_READ)) begin
                        r_state <= in_deb ? S_HIST : S_LATEST;
                    end
                end
                S_LATEST: begin
                    r_sel   <= r_lat_vld_q ? lat_rdata : '0;
                    r_state <= S_SCALE;
                end
                S_HIST: begin
                    r_lo  <= n_lo;
                    r_hi  <= n_hi;
                    r_sum <= n_sum;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(HIST_DEPTH - 1)) begin
                        r_sel   <= trimmed[SAMPLE_BITS-1:0];
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (out_free) begin
                        m_axis_tdata  <= product[SCALE_SHIFT +: VALUE_W];
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* sv/adctm_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module adctm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
